### src/wam_pkg.sv
`timescale 1ns / 1ps

package wam_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int CHANNELS    = 8;

    localparam int MASK_W = 8;
    localparam int ID_W   = 8;

    // Operation codes carried in the mode field
    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_SET_EN = 3'd2;
    localparam logic [2:0] MODE_UPDATE = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;
    localparam logic [2:0] MODE_READ   = 3'd5;
    localparam logic [2:0] MODE_CHECK  = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    // Register index of the channel mask on the APB port
    localparam logic REG_CHANNEL_MASK = 1'b0;

    typedef struct packed {
        logic [4:0]      hour;
        logic [5:0]      minute;
        logic [2:0]      day;
        logic [2:0]      channel;
        logic [ID_W-1:0] id;
        logic            enabled;
    } entry_t;

    // Declared high to low so mode lands in the lowest bits of tdata
    typedef struct packed {
        logic       actuator_on;
        logic       enable_flag;
        logic [2:0] channel;
        logic [2:0] day;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [7:0] entry_index;
        logic [7:0] sched_id;
        logic [2:0] mode;
    } item_t;

    localparam int ITEM_W  = $bits(item_t);
    localparam int S_TDATA_W = ((ITEM_W + 7) / 8) * 8;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_START   = 7'b0000010,
        S_FETCH   = 7'b0000100,
        S_EXAM    = 7'b0001000,
        S_SHFETCH = 7'b0010000,
        S_SHMOVE  = 7'b0100000,
        S_OUT     = 7'b1000000
    } state_t;

endpackage

### src/weekly_alarm_match_table.sv
`timescale 1ns / 1ps

// Sequence: add, clear and unused modes pass from the start state straight to output; read
//   fetches and examines the indexed entry; remove, set enable, update and check fetch and
//   examine entries in turn until one decides; remove moves each later entry down one place.
// Flow: one item at a time; s_tready returns at the edge that loads the result, and a
//   result the sink has not taken yet holds the next item before its result is loaded.
//   The one-read-port table memory and the single compare unit walk entries one at a time.
// Reset: table empty, next id 1, channel mask 0, no result pending; table contents undefined.
module weekly_alarm_match_table #(
    parameter int ENTRIES = wam_pkg::ENTRIES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // tdata: mode, sched_id, entry_index, hour, minute, day, channel, enable_flag,
    //        actuator_on (from bit 0 up), zero pad to bytes
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [wam_pkg::S_TDATA_W-1:0]  s_tdata,
    // tdata: status, new_id, entry_count, out_hour, out_minute, out_day, out_channel,
    //        out_id, out_enabled, activate (from bit 0 up), zero pad to bytes
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [((37 + $clog2(ENTRIES + 1) + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import wam_pkg::*;

    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RES_W     = 37 + CNT_W;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

    // ---------------------------------------------------------------
    // Configuration: channel mask, written in the APB access phase
    // ---------------------------------------------------------------
    logic [MASK_W-1:0] mask_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CHANNEL_MASK) ? 32'(mask_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_CHANNEL_MASK) begin
            mask_reg <= pwdata[MASK_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Entry table: one write port, one registered read port
    // ---------------------------------------------------------------
    entry_t             mem [ENTRIES];
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    entry_t             rdata_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    state_t             state_reg,    state_next;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic [ID_W-1:0]    next_id_reg,  next_id_next;
    logic [IDX_W-1:0]   ptr_reg,      ptr_next;
    item_t              op_reg,       op_next;
    logic [1:0]         status_reg,   status_next;
    logic [ID_W-1:0]    new_id_reg,   new_id_next;
    logic               act_reg,      act_next;
    entry_t             rd_reg,       rd_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [CNT_W:0]     count_ext;
    logic [CNT_W:0]     ptr_plus1;
    logic [CNT_W:0]     ptr_plus2;
    logic               last_entry;
    logic               id_hit;
    logic               due_hit;
    logic               chan_gate;
    logic               out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign count_ext  = (CNT_W + 1)'(count_reg);
    assign ptr_plus1  = (CNT_W + 1)'(ptr_reg) + 1'b1;
    assign ptr_plus2  = (CNT_W + 1)'(ptr_reg) + 2'd2;
    assign last_entry = (ptr_plus1 >= count_ext);

    // The shared compare unit: id lookup and alarm match on the fetched entry
    assign id_hit  = (rdata_reg.id == op_reg.sched_id);
    assign due_hit = rdata_reg.enabled && rdata_reg.channel == op_reg.channel &&
                     rdata_reg.day == op_reg.day && rdata_reg.hour == op_reg.hour &&
                     rdata_reg.minute == op_reg.minute;

    // Channel must exist, carry an actuator, and that actuator must be off
    assign chan_gate = ({1'b0, op_reg.channel} < 4'(CHANNELS)) &&
                       mask_reg[op_reg.channel] && !op_reg.actuator_on;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        next_id_next  = next_id_reg;
        ptr_next      = ptr_reg;
        op_next       = op_reg;
        status_next   = status_reg;
        new_id_next   = new_id_reg;
        act_next      = act_reg;
        rd_next       = rd_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mem_we        = 1'b0;
        mem_waddr     = ptr_reg;
        mem_wdata     = rdata_reg;
        mem_raddr     = ptr_reg;

        // Drop the result beat once the sink takes it
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                // Capture the beat and clear the result fields
                if (s_tvalid) begin
                    op_next     = item_t'(s_tdata[ITEM_W-1:0]);
                    status_next = ST_OK;
                    new_id_next = '0;
                    act_next    = 1'b0;
                    rd_next     = '0;
                    ptr_next    = '0;
                    state_next  = S_START;
                end
            end

            S_START: begin
                state_next = S_OUT;
                unique case (op_reg.mode)
                    MODE_ADD: begin
                        if (count_reg < CNT_W'(ENTRIES)) begin
                            mem_we            = 1'b1;
                            mem_waddr         = count_reg[IDX_W-1:0];
                            mem_wdata.hour    = op_reg.hour;
                            mem_wdata.minute  = op_reg.minute;
                            mem_wdata.day     = op_reg.day;
                            mem_wdata.channel = op_reg.channel;
                            mem_wdata.id      = next_id_reg;
                            mem_wdata.enabled = 1'b1;
                            new_id_next       = next_id_reg;
                            next_id_next      = next_id_reg + 1'b1;
                            count_next        = count_reg + 1'b1;
                        end else begin
                            status_next = ST_FULL;
                        end
                    end
                    MODE_REMOVE, MODE_SET_EN, MODE_UPDATE: begin
                        if (count_reg == '0) begin
                            status_next = ST_NOT_FOUND;
                        end else begin
                            state_next = S_FETCH;
                        end
                    end
                    MODE_CLEAR: begin
                        count_next = '0;
                    end
                    MODE_READ: begin
                        if (op_reg.entry_index < 8'(count_reg)) begin
                            ptr_next   = op_reg.entry_index[IDX_W-1:0];
                            state_next = S_FETCH;
                        end else begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    MODE_CHECK: begin
                        if (chan_gate && count_reg != '0) begin
                            state_next = S_FETCH;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_FETCH: begin
                mem_raddr  = ptr_reg;
                state_next = S_EXAM;
            end

            S_EXAM: begin
                state_next = S_OUT;
                unique case (op_reg.mode)
                    MODE_READ: begin
                        rd_next = rdata_reg;
                    end
                    MODE_REMOVE, MODE_SET_EN, MODE_UPDATE: begin
                        if (id_hit) begin
                            if (op_reg.mode == MODE_SET_EN) begin
                                mem_we            = 1'b1;
                                mem_wdata.enabled = op_reg.enable_flag;
                            end else if (op_reg.mode == MODE_UPDATE) begin
                                mem_we            = 1'b1;
                                mem_wdata.hour    = op_reg.hour;
                                mem_wdata.minute  = op_reg.minute;
                                mem_wdata.day     = op_reg.day;
                                mem_wdata.channel = op_reg.channel;
                            end else if (!last_entry) begin
                                // Close the gap: pull each later entry down one place
                                state_next = S_SHFETCH;
                            end else begin
                                count_next = count_reg - 1'b1;
                            end
                        end else if (last_entry) begin
                            status_next = ST_NOT_FOUND;
                        end else begin
                            ptr_next   = ptr_plus1[IDX_W-1:0];
                            state_next = S_FETCH;
                        end
                    end
                    MODE_CHECK: begin
                        if (due_hit) begin
                            act_next = 1'b1;
                        end else if (!last_entry) begin
                            ptr_next   = ptr_plus1[IDX_W-1:0];
                            state_next = S_FETCH;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            S_SHFETCH: begin
                mem_raddr  = ptr_plus1[IDX_W-1:0];
                state_next = S_SHMOVE;
            end

            S_SHMOVE: begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = rdata_reg;
                ptr_next  = ptr_plus1[IDX_W-1:0];
                if (ptr_plus2 < count_ext) begin
                    state_next = S_SHFETCH;
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = S_OUT;
                end
            end

            S_OUT: begin
                // Hold until the output register is free, then load the result beat
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({act_reg, rd_reg.enabled, rd_reg.id,
                                                rd_reg.channel, rd_reg.day, rd_reg.minute,
                                                rd_reg.hour, count_reg, new_id_reg,
                                                status_reg});
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            next_id_reg  <= ID_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            next_id_reg  <= next_id_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge aclk) begin
        ptr_reg     <= ptr_next;
        op_reg      <= op_next;
        status_reg  <= status_next;
        new_id_reg  <= new_id_next;
        act_reg     <= act_next;
        rd_reg      <= rd_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

### test/tb_weekly_alarm_match_table.sv
`timescale 1ns / 1ps

module tb_weekly_alarm_match_table;
    import wam_pkg::*;

    localparam int ENTRIES       = ENTRIES_DEF;
    localparam int M_TDATA_W     = ((37 + $clog2(ENTRIES + 1) + 7) / 8) * 8;
    localparam int CYCLE_LIMIT   = 400000;
    // Worst walk: lookup over the whole table plus the shift behind the hit
    localparam int SETTLE_CYCLES = 4 * ENTRIES + 16;
    localparam int MAX_PRINTS    = 40;

    // Mode 7 has no operation behind it; the block must answer ok and change nothing
    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam logic [2:0] MASK_ADDR   = 3'(4 * int'(REG_CHANNEL_MASK));

    // Result beat, declared high to low so status lands in bit 0 of m_tdata
    typedef struct packed {
        logic       activate;
        logic       out_enabled;
        logic [7:0] out_id;
        logic [2:0] out_channel;
        logic [2:0] out_day;
        logic [5:0] out_minute;
        logic [4:0] out_hour;
        logic [4:0] entry_count;
        logic [7:0] new_id;
        logic [1:0] status;
    } alarm_reply_t;

    localparam int REPLY_W = $bits(alarm_reply_t);

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    // tdata: mode, sched_id, entry_index, hour, minute, day, channel, enable_flag,
    //        actuator_on (from bit 0 up), zero pad to bytes
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [2:0]            paddr    = '0;
    logic [31:0]           pwdata   = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    // tdata: status, new_id, entry_count, out_hour, out_minute, out_day, out_channel,
    //        out_id, out_enabled, activate (from bit 0 up), zero pad to bytes
    wire [M_TDATA_W-1:0]   m_tdata;
    wire [31:0]            prdata;
    wire                   pready;

    weekly_alarm_match_table #(
        .ENTRIES(ENTRIES)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the alarm table, its fill level, the id counter and the mask
    entry_t       shadow_tbl [ENTRIES];
    int           shadow_count   = 0;
    logic [7:0]   shadow_next_id = 8'd1;
    logic [7:0]   shadow_mask    = 8'h00;

    // Replies predicted for accepted operations, oldest first
    alarm_reply_t pending_replies [$];
    alarm_reply_t last_predicted;

    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int rx_hold_cycles = 0;
    int mismatches     = 0;
    int cycle_count    = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Abort a hung run: count every clock and give up far beyond the slowest good run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, pending_replies.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: either hold off for a counted stretch or stall at random
    always @(negedge aclk) begin
        if (rx_hold_cycles > 0) begin
            m_tready <= 1'b0;
            rx_hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic compare_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Compute the reply to one operation and advance the shadow table
    function automatic alarm_reply_t predict_reply(item_t op);
        alarm_reply_t r;
        entry_t       e;
        int           hit;
        r   = '0;
        hit = -1;
        // First entry in table order wins when ids repeat after a wrap
        for (int i = shadow_count - 1; i >= 0; i--)
            if (shadow_tbl[i].id == op.sched_id)
                hit = i;
        case (op.mode)
            MODE_ADD: begin
                if (shadow_count < ENTRIES) begin
                    shadow_tbl[shadow_count] = '{hour: op.hour, minute: op.minute,
                                                 day: op.day, channel: op.channel,
                                                 id: shadow_next_id, enabled: 1'b1};
                    r.new_id       = shadow_next_id;
                    shadow_next_id = shadow_next_id + 8'd1;
                    shadow_count++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            MODE_REMOVE: begin
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    // Close the gap so the table keeps its order
                    for (int i = hit; i < shadow_count - 1; i++)
                        shadow_tbl[i] = shadow_tbl[i + 1];
                    shadow_count--;
                end
            end
            MODE_SET_EN: begin
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                    shadow_tbl[hit].enabled = op.enable_flag;
            end
            MODE_UPDATE: begin
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    shadow_tbl[hit].hour    = op.hour;
                    shadow_tbl[hit].minute  = op.minute;
                    shadow_tbl[hit].day     = op.day;
                    shadow_tbl[hit].channel = op.channel;
                end
            end
            MODE_CLEAR: begin
                shadow_count = 0;
            end
            MODE_READ: begin
                if (int'(op.entry_index) < shadow_count) begin
                    e             = shadow_tbl[op.entry_index];
                    r.out_hour    = e.hour;
                    r.out_minute  = e.minute;
                    r.out_day     = e.day;
                    r.out_channel = e.channel;
                    r.out_id      = e.id;
                    r.out_enabled = e.enabled;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            MODE_CHECK: begin
                // Fire only for a registered actuator that is currently off
                if (shadow_mask[op.channel] && !op.actuator_on)
                    for (int i = 0; i < shadow_count; i++)
                        if (shadow_tbl[i].enabled && shadow_tbl[i].channel == op.channel &&
                            shadow_tbl[i].day == op.day && shadow_tbl[i].hour == op.hour &&
                            shadow_tbl[i].minute == op.minute)
                            r.activate = 1'b1;
            end
            default: begin
            end
        endcase
        r.entry_count = 5'(shadow_count);
        return r;
    endfunction

    // Check each result beat against the oldest prediction
    always @(posedge aclk) begin
        alarm_reply_t got;
        alarm_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = alarm_reply_t'(m_tdata[REPLY_W-1:0]);
            if (pending_replies.size() == 0) begin
                report_mismatch("result beat with nothing pending", m_tdata, '0);
            end else begin
                want = pending_replies.pop_front();
                compare_field("status",      got.status,      want.status);
                compare_field("new_id",      got.new_id,      want.new_id);
                compare_field("entry_count", got.entry_count, want.entry_count);
                compare_field("out_hour",    got.out_hour,    want.out_hour);
                compare_field("out_minute",  got.out_minute,  want.out_minute);
                compare_field("out_day",     got.out_day,     want.out_day);
                compare_field("out_channel", got.out_channel, want.out_channel);
                compare_field("out_id",      got.out_id,      want.out_id);
                compare_field("out_enabled", got.out_enabled, want.out_enabled);
                compare_field("activate",    got.activate,    want.activate);
                compare_field("tdata pad",   m_tdata[M_TDATA_W-1:REPLY_W], '0);
            end
        end
    end

    function automatic item_t mk_op(logic [2:0] mode, logic [7:0] sid, logic [7:0] idx,
                                    logic [4:0] hr, logic [5:0] mn, logic [2:0] dy,
                                    logic [2:0] ch, logic en, logic act);
        item_t op;
        op.mode        = mode;
        op.sched_id    = sid;
        op.entry_index = idx;
        op.hour        = hr;
        op.minute      = mn;
        op.day         = dy;
        op.channel     = ch;
        op.enable_flag = en;
        op.actuator_on = act;
        return op;
    endfunction

    // Mostly well-formed operations aimed at live ids, indexes and due times
    function automatic item_t rand_op();
        item_t op;
        int    pick;
        int    k;
        op.sched_id    = 8'($urandom_range(255));
        op.entry_index = 8'($urandom_range(255));
        // Now and then use field values past the calendar range; they are stored as is
        op.hour   = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(23));
        op.minute = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(59));
        op.day    = ($urandom_range(9) == 0) ? 3'($urandom_range(7))  : 3'($urandom_range(6));
        op.channel     = 3'($urandom_range(7));
        op.enable_flag = 1'($urandom_range(1));
        op.actuator_on = ($urandom_range(3) == 0);
        k    = (shadow_count > 0) ? $urandom_range(shadow_count - 1) : 0;
        pick = $urandom_range(99);
        if (pick < 30) begin
            op.mode = MODE_ADD;
        end else if (pick < 42) begin
            op.mode = MODE_REMOVE;
            if (shadow_count > 0 && $urandom_range(4) != 0)
                op.sched_id = shadow_tbl[k].id;
        end else if (pick < 54) begin
            op.mode = MODE_SET_EN;
            if (shadow_count > 0 && $urandom_range(4) != 0)
                op.sched_id = shadow_tbl[k].id;
        end else if (pick < 64) begin
            op.mode = MODE_UPDATE;
            if (shadow_count > 0 && $urandom_range(4) != 0)
                op.sched_id = shadow_tbl[k].id;
        end else if (pick < 76) begin
            op.mode = MODE_READ;
            if (shadow_count > 0 && $urandom_range(4) != 0)
                op.entry_index = 8'(k);
        end else if (pick < 96) begin
            op.mode = MODE_CHECK;
            // Ask about a stored alarm at its own time so that hits are common
            if (shadow_count > 0 && $urandom_range(6) != 0) begin
                op.hour    = shadow_tbl[k].hour;
                op.minute  = shadow_tbl[k].minute;
                op.day     = shadow_tbl[k].day;
                op.channel = shadow_tbl[k].channel;
            end
        end else if (pick < 98) begin
            op.mode = MODE_CLEAR;
        end else begin
            op.mode = MODE_UNUSED;
        end
        return op;
    endfunction

    // Send one operation: idle at random first, then hold the beat until accepted
    task automatic push_op(item_t op);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(op);
        do @(posedge aclk); while (!s_tready);
        last_predicted = predict_reply(op);
        pending_replies.push_back(last_predicted);
    endtask

    // Drop the input and wait until every predicted reply has been checked
    task automatic drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge aclk);
    endtask

    // Write the channel mask over APB, then read it back; call only with the block idle
    task automatic write_mask(logic [7:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MASK_ADDR;
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        shadow_mask = value;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        compare_field("channel mask readback", prdata, 32'(value));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Lookups on an empty table, and the unused mode with every input bit high
    task automatic test_empty_table();
        push_op(mk_op(MODE_READ,   8'd0, 8'd0, 5'd0, 6'd0, 3'd0, 3'd0, 1'b0, 1'b0));
        push_op(mk_op(MODE_REMOVE, 8'd1, 8'd0, 5'd0, 6'd0, 3'd0, 3'd0, 1'b0, 1'b0));
        push_op(mk_op(MODE_UPDATE, 8'd0, 8'd0, 5'd5, 6'd5, 3'd1, 3'd1, 1'b0, 1'b0));
        push_op(mk_op(MODE_UNUSED, 8'hFF, 8'hFF, 5'd31, 6'd63, 3'd7, 3'd7, 1'b1, 1'b1));
    endtask

    // Fill to capacity with extreme fields, overflow, then exercise every lookup path
    task automatic test_fill_table();
        entry_t e;
        for (int i = 0; i < ENTRIES; i++) begin
            if (i == 0)
                push_op(mk_op(MODE_ADD, 8'd0, 8'd0, 5'd0, 6'd0, 3'd0, 3'd0, 1'b0, 1'b0));
            else if (i == 1)
                push_op(mk_op(MODE_ADD, 8'd0, 8'd0, 5'd31, 6'd63, 3'd7, 3'd7, 1'b0, 1'b0));
            else
                push_op(mk_op(MODE_ADD, 8'd0, 8'd0, 5'($urandom_range(23)),
                              6'($urandom_range(59)), 3'($urandom_range(6)), 3'(i % 8),
                              1'b0, 1'b0));
        end
        // Table full: add must fail and leave everything alone
        push_op(mk_op(MODE_ADD,  8'd0, 8'd0, 5'd1, 6'd2, 3'd3, 3'd4, 1'b0, 1'b0));
        push_op(mk_op(MODE_READ, 8'd0, 8'(ENTRIES), 5'd0, 6'd0, 3'd0, 3'd0, 1'b0, 1'b0));
        push_op(mk_op(MODE_READ, 8'd0, 8'hFF, 5'd0, 6'd0, 3'd0, 3'd0, 1'b0, 1'b0));
        // Due alarm: suppressed while the actuator is on, fires when it is off
        e = shadow_tbl[2];
        push_op(mk_op(MODE_CHECK, 8'd0, 8'd0, e.hour, e.minute, e.day, e.channel, 1'b0, 1'b1));
        push_op(mk_op(MODE_CHECK, 8'd0, 8'd0, e.hour, e.minute, e.day, e.channel, 1'b0, 1'b0));
        // Disabled alarm never fires
        push_op(mk_op(MODE_SET_EN, e.id, 8'd0, 5'd0, 6'd0, 3'd0, 3'd0, 1'b0, 1'b0));
        push_op(mk_op(MODE_CHECK, 8'd0, 8'd0, e.hour, e.minute, e.day, e.channel, 1'b0, 1'b0));
        push_op(mk_op(MODE_UPDATE, shadow_tbl[3].id, 8'd0, 5'd23, 6'd59, 3'd6, 3'd5,
                      1'b0, 1'b0));
        push_op(mk_op(MODE_READ, 8'd0, 8'd3, 5'd0, 6'd0, 3'd0, 3'd0, 1'b0, 1'b0));
        // Remove near the front so most of the table shifts down
        push_op(mk_op(MODE_REMOVE, shadow_tbl[1].id, 8'd0, 5'd0, 6'd0, 3'd0, 3'd0, 1'b0, 1'b0));
        push_op(mk_op(MODE_READ, 8'd0, 8'd1, 5'd0, 6'd0, 3'd0, 3'd0, 1'b0, 1'b0));
    endtask

    // Run the id counter through its wrap until id 0 is issued, then look that entry up
    task automatic test_id_wrap();
        bit issued_zero;
        issued_zero = 1'b0;
        push_op(mk_op(MODE_CLEAR, 8'd0, 8'd0, 5'd0, 6'd0, 3'd0, 3'd0, 1'b0, 1'b0));
        while (!issued_zero) begin
            // Empty the table whenever it fills so every add issues an id
            if (shadow_count == ENTRIES)
                push_op(mk_op(MODE_CLEAR, 8'd0, 8'd0, 5'd0, 6'd0, 3'd0, 3'd0, 1'b0, 1'b0));
            push_op(mk_op(MODE_ADD, 8'd0, 8'd0, 5'($urandom_range(23)), 6'($urandom_range(59)),
                          3'($urandom_range(6)), 3'($urandom_range(7)), 1'b0, 1'b0));
            if (last_predicted.status == ST_OK && last_predicted.new_id == 8'd0)
                issued_zero = 1'b1;
        end
        // Id 0 sits at the end of the table: read it back, disable it, then remove it
        push_op(mk_op(MODE_READ, 8'd0, 8'(shadow_count - 1), 5'd0, 6'd0, 3'd0, 3'd0,
                      1'b0, 1'b0));
        push_op(mk_op(MODE_SET_EN, 8'd0, 8'd0, 5'd0, 6'd0, 3'd0, 3'd0, 1'b0, 1'b0));
        push_op(mk_op(MODE_REMOVE, 8'd0, 8'd0, 5'd0, 6'd0, 3'd0, 3'd0, 1'b0, 1'b0));
    endtask

    task automatic test_random(int count);
        repeat (count) push_op(rand_op());
    endtask

    // Hold the result side off long enough that the block backs up and stalls input
    task automatic test_backpressure();
        rx_hold_cycles = 300;
        repeat (12) push_op(rand_op());
        drain();
    endtask

    initial begin
        // Sender idles 37%, receiver 52%
        tx_idle_pct = 37;
        rx_idle_pct = 52;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Mask is still at its reset value of zero here
        test_empty_table();
        drain();
        write_mask(8'hFF);
        test_fill_table();
        test_random(40);

        // Swap the idling ratios and move to a partial mask
        drain();
        tx_idle_pct = 52;
        rx_idle_pct = 37;
        write_mask(8'($urandom_range(1, 254)));
        test_backpressure();
        test_random(30);
        drain();
        write_mask(8'h00);
        test_random(10);

        // No idling on either side
        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_mask(8'hFF);
        test_id_wrap();
        test_random(30);

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
src/wam_pkg.sv
src/weekly_alarm_match_table.sv
test/tb_weekly_alarm_match_table.sv
